FILE: rtl/core/ddb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddb_pkg
// Shared types and codes for the decode dispatch buffer: request codes,
// operation class boundaries, controller states and the control bundles.
// ----------------------------------------------------------------------------
package ddb_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_READY  = 3'd2,
    REQ_SPOTS  = 3'd3,
    REQ_TICK   = 3'd4
  } req_e_t;

  // last class code of each downstream queue group
  localparam logic [2:0] CLS_BRANCH = 3'd1;
  localparam logic [2:0] CLS_STORE  = 3'd3;
  localparam logic [2:0] CLS_FP_MUL = 3'd5;

  // remaining-cycle value that marks an entry ready
  localparam logic [3:0] CYCLES_READY = 4'd1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ddb_cmd_t;

  typedef struct packed {
    logic walk_end;
  } ddb_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/ddb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddb_ctrl
// Request sequencer: takes an item, steps the datapath walk one entry per
// cycle and commits when the datapath reports the end of the walk.
// ----------------------------------------------------------------------------
module ddb_ctrl
  import ddb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire ddb_status_t status,
  output ddb_cmd_t         cmd,
  output logic             busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (status.walk_end) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/ddb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddb_datapath
// Entry storage with collapse on remove, the walk index and charge counters
// for the serial searches, and the result registers.
// ----------------------------------------------------------------------------
module ddb_datapath
  import ddb_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 8,
  parameter int DECODE_LATENCY = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ddb_cmd_t    cmd,
  output ddb_status_t      status,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] instr_addr,
  input  wire logic [2:0]  op_class,
  input  wire logic [2:0]  skip,
  input  wire logic [5:0]  free_active,
  input  wire logic [4:0]  free_int,
  input  wire logic [4:0]  free_address,
  input  wire logic [4:0]  free_fp,
  output logic             done,
  output logic             accepted,
  output logic             ready_valid,
  output logic [31:0]      ready_addr,
  output logic [3:0]       free_spots,
  output logic [3:0]       occupancy
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [3:0]    LATENCY_C = 4'(DECODE_LATENCY);

  logic [31:0]   slot_addr   [QUEUE_DEPTH];
  logic [2:0]    slot_class  [QUEUE_DEPTH];
  logic [3:0]    slot_cycles [QUEUE_DEPTH];
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  logic [2:0]    req;
  logic [31:0]   key;
  logic [2:0]    cls;
  logic [2:0]    skip_q;
  logic [5:0]    act_cnt;
  logic [4:0]    int_cnt;
  logic [4:0]    addr_cnt;
  logic [4:0]    fp_cnt;
  logic [2:0]    seen;
  logic [CW-1:0] idx;

  logic [IW-1:0] kidx;
  logic          at_end;
  logic          full;
  logic [31:0]   cur_addr;
  logic [2:0]    cur_class;
  logic [3:0]    cur_cycles;
  logic          cur_ready;
  logic          q_blocked;
  logic          add_ok;
  logic          remove_hit;
  logic [CW:0]   spots_sum;

  assign kidx       = idx[IW-1:0];
  assign at_end     = (idx == fill);
  assign full       = (fill == DEPTH_C);
  assign cur_addr   = slot_addr[kidx];
  assign cur_class  = slot_class[kidx];
  assign cur_cycles = slot_cycles[kidx];
  assign cur_ready  = (cur_cycles == CYCLES_READY);
  assign add_ok     = (req == REQ_ADD) && !full;
  assign remove_hit = (req == REQ_REMOVE) && !at_end;
  // entries passed by the walk equal the stop index
  assign spots_sum  = {1'b0, DEPTH_C} - {1'b0, fill} + {1'b0, idx};

  // the downstream queue that the current entry would need has no spot left
  always_comb begin
    if (cur_class <= CLS_BRANCH) begin
      q_blocked = (int_cnt == 5'd0);
    end else if (cur_class <= CLS_STORE) begin
      q_blocked = (addr_cnt == 5'd0);
    end else if (cur_class <= CLS_FP_MUL) begin
      q_blocked = (fp_cnt == 5'd0);
    end else begin
      q_blocked = 1'b0;
    end
  end

  always_comb begin
    case (req)
      REQ_REMOVE: status.walk_end = at_end || (cur_addr == key);
      REQ_READY:  status.walk_end = at_end || (cur_ready && (seen == skip_q));
      REQ_SPOTS:  status.walk_end = at_end || (act_cnt == 6'd0) || q_blocked;
      default:    status.walk_end = 1'b1;
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (add_ok) begin
      fill_next = fill + CW'(1);
    end else if (remove_hit) begin
      fill_next = fill - CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        fill <= fill_next;
      end
    end
  end

  // request capture and walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= req_type;
      key      <= instr_addr;
      cls      <= op_class;
      skip_q   <= skip;
      act_cnt  <= free_active;
      int_cnt  <= free_int;
      addr_cnt <= free_address;
      fp_cnt   <= free_fp;
      seen     <= '0;
      idx      <= '0;
    end else if (cmd.step && !cmd.finish) begin
      idx <= idx + CW'(1);
      if (cur_ready) begin
        seen <= seen + 3'd1;
      end
      act_cnt <= act_cnt - 6'd1;
      if (cur_class <= CLS_BRANCH) begin
        int_cnt <= int_cnt - 5'd1;
      end else if (cur_class <= CLS_STORE) begin
        addr_cnt <= addr_cnt - 5'd1;
      end else if (cur_class <= CLS_FP_MUL) begin
        fp_cnt <= fp_cnt - 5'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (add_ok) begin
        slot_addr[fill[IW-1:0]]   <= key;
        slot_class[fill[IW-1:0]]  <= cls;
        slot_cycles[fill[IW-1:0]] <= LATENCY_C;
      end
      if (remove_hit) begin
        // close the gap from the matched entry upwards
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
          if (CW'(j) >= idx) begin
            slot_addr[j]   <= slot_addr[j+1];
            slot_class[j]  <= slot_class[j+1];
            slot_cycles[j] <= slot_cycles[j+1];
          end
        end
      end
      if (req == REQ_TICK) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (slot_cycles[j] > CYCLES_READY) begin
            slot_cycles[j] <= slot_cycles[j] - 4'd1;
          end
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      accepted    <= add_ok || remove_hit;
      ready_valid <= (req == REQ_READY) && !at_end;
      ready_addr  <= ((req == REQ_READY) && !at_end) ? cur_addr : 32'd0;
      free_spots  <= (req == REQ_SPOTS) ? spots_sum[3:0] : 4'd0;
      occupancy   <= 4'(fill_next);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("fill count beyond queue depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> idx <= fill)
    else $error("walk index passed the last entry");

  a_fill_on_commit: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> $past(cmd.finish))
    else $error("fill count changed outside a commit");

  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("commit without a result strobe");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/decode_dispatch_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decode_dispatch_buffer
// In-order decode queue with add, collapsing remove, ready query, free-spot
// query and countdown tick, built as a sequencer and an entry datapath.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Add, tick and unknown
// request types go straight from the walk state to the commit, and done is
// registered from the commit. Remove, ready query and free-spot query walk the
// entries from the head at one entry per cycle through a single compare on the
// walk index and commit when the walk stops, after passing at most the
// occupancy. Results sit on the output ports for the one cycle that done is
// high and must be taken then; a new item may be started in that same cycle.
module decode_dispatch_buffer
  import ddb_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 8,
  parameter int DECODE_LATENCY = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] instr_addr,
  input  wire logic [2:0]  op_class,
  input  wire logic [2:0]  skip,
  input  wire logic [5:0]  free_active,
  input  wire logic [4:0]  free_int,
  input  wire logic [4:0]  free_address,
  input  wire logic [4:0]  free_fp,
  output logic             done,
  output logic             accepted,
  output logic             ready_valid,
  output logic [31:0]      ready_addr,
  output logic [3:0]       free_spots,
  output logic [3:0]       occupancy
);

  ddb_cmd_t    cmd;
  ddb_status_t status;

  ddb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ddb_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .DECODE_LATENCY (DECODE_LATENCY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .instr_addr   (instr_addr),
    .op_class     (op_class),
    .skip         (skip),
    .free_active  (free_active),
    .free_int     (free_int),
    .free_address (free_address),
    .free_fp      (free_fp),
    .done         (done),
    .accepted     (accepted),
    .ready_valid  (ready_valid),
    .ready_addr   (ready_addr),
    .free_spots   (free_spots),
    .occupancy    (occupancy)
  );

endmodule
`default_nettype wire

FILE: bench/dispatch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches the request and result ports of the decode dispatch buffer, keeps
// its own copy of the entry queue, and compares every result with the answer
// worked out for the request that caused it.
// ----------------------------------------------------------------------------
module dispatch_checker
  import ddb_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 8,
  parameter int DECODE_LATENCY = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] instr_addr,
  input  wire logic [2:0]  op_class,
  input  wire logic [2:0]  skip,
  input  wire logic [5:0]  free_active,
  input  wire logic [4:0]  free_int,
  input  wire logic [4:0]  free_address,
  input  wire logic [4:0]  free_fp,
  input  wire logic        done,
  input  wire logic        accepted,
  input  wire logic        ready_valid,
  input  wire logic [31:0] ready_addr,
  input  wire logic [3:0]  free_spots,
  input  wire logic [3:0]  occupancy,
  output int               errors,
  output int               outstanding,
  output int               checked
);

  typedef struct packed {
    logic        accepted;
    logic        ready_valid;
    logic [31:0] ready_addr;
    logic [3:0]  free_spots;
    logic [3:0]  occupancy;
  } buffer_answer_t;

  // shadow of the entry queue
  logic [31:0] entry_addr   [QUEUE_DEPTH];
  logic [2:0]  entry_class  [QUEUE_DEPTH];
  logic [3:0]  entry_cycles [QUEUE_DEPTH];
  int          entry_count;

  buffer_answer_t answers_due[$];

  function automatic buffer_answer_t apply_request(
    input logic [2:0]  req,
    input logic [31:0] addr,
    input logic [2:0]  cls,
    input logic [2:0]  sk,
    input logic [5:0]  act_in,
    input logic [4:0]  iq_in,
    input logic [4:0]  aq_in,
    input logic [4:0]  fq_in
  );
    buffer_answer_t ans;
    int          k;
    int          hit;
    int          seen;
    int          passed;
    logic        stopped;
    logic [5:0]  act;
    logic [4:0]  iq;
    logic [4:0]  aq;
    logic [4:0]  fq;
    ans = '0;
    act = act_in;
    iq = iq_in;
    aq = aq_in;
    fq = fq_in;
    case (req)
      REQ_ADD: begin
        if (entry_count < QUEUE_DEPTH) begin
          entry_addr[entry_count] = addr;
          entry_class[entry_count] = cls;
          entry_cycles[entry_count] = 4'(DECODE_LATENCY);
          entry_count++;
          ans.accepted = 1'b1;
        end
      end
      REQ_REMOVE: begin
        hit = -1;
        for (k = 0; k < entry_count; k++)
          if (hit < 0 && entry_addr[k] == addr) hit = k;
        if (hit >= 0) begin
          // close the gap behind the removed entry
          for (k = hit; k < entry_count - 1; k++) begin
            entry_addr[k] = entry_addr[k+1];
            entry_class[k] = entry_class[k+1];
            entry_cycles[k] = entry_cycles[k+1];
          end
          entry_count--;
          ans.accepted = 1'b1;
        end
      end
      REQ_READY: begin
        seen = 0;
        for (k = 0; k < entry_count; k++) begin
          if (!ans.ready_valid && entry_cycles[k] == CYCLES_READY) begin
            if (seen == int'(sk)) begin
              ans.ready_valid = 1'b1;
              ans.ready_addr = entry_addr[k];
            end
            seen++;
          end
        end
      end
      REQ_SPOTS: begin
        passed = 0;
        stopped = 1'b0;
        for (k = 0; k < entry_count; k++) begin
          if (!stopped) begin
            if (act == 0) stopped = 1'b1;
            else if (entry_class[k] <= CLS_BRANCH) begin
              if (iq == 0) stopped = 1'b1;
              else iq--;
            end else if (entry_class[k] <= CLS_STORE) begin
              if (aq == 0) stopped = 1'b1;
              else aq--;
            end else if (entry_class[k] <= CLS_FP_MUL) begin
              if (fq == 0) stopped = 1'b1;
              else fq--;
            end
            // classes above fp multiply only take an active list spot
            if (!stopped) begin
              act--;
              passed++;
            end
          end
        end
        ans.free_spots = 4'(QUEUE_DEPTH - entry_count + passed);
      end
      REQ_TICK: begin
        for (k = 0; k < entry_count; k++)
          if (entry_cycles[k] > CYCLES_READY) entry_cycles[k]--;
      end
      default: ;
    endcase
    ans.occupancy = 4'(entry_count);
    return ans;
  endfunction

  always @(posedge clk) begin
    buffer_answer_t want;
    buffer_answer_t got;
    if (rst) begin
      entry_count = 0;
      answers_due.delete();
      errors = 0;
      outstanding = 0;
      checked = 0;
    end else begin
      if (done === 1'b1) begin
        got = {accepted, ready_valid, ready_addr, free_spots, occupancy};
        checked++;
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing outstanding: acc %b rv %b ra %h fs %0d occ %0d",
                     $realtime, got.accepted, got.ready_valid, got.ready_addr,
                     got.free_spots, got.occupancy);
        end else begin
          want = answers_due.pop_front();
          if (got.accepted !== want.accepted || got.ready_valid !== want.ready_valid ||
              got.ready_addr !== want.ready_addr || got.free_spots !== want.free_spots ||
              got.occupancy !== want.occupancy) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected acc %b rv %b ra %h fs %0d occ %0d",
                       $realtime, want.accepted, want.ready_valid, want.ready_addr,
                       want.free_spots, want.occupancy);
              $display("%0t:           got      acc %b rv %b ra %h fs %0d occ %0d",
                       $realtime, got.accepted, got.ready_valid, got.ready_addr,
                       got.free_spots, got.occupancy);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        answers_due.push_back(apply_request(req_type, instr_addr, op_class, skip,
                                            free_active, free_int, free_address,
                                            free_fp));
      outstanding = answers_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the decode dispatch buffer with a directed opening (empty and full
// queue, every request type, ready and free-spot corner cases, duplicate
// removal) followed by phased random traffic with random gaps; the checker
// beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top;
  import ddb_pkg::*;

  localparam int RANDOM_ITEMS = 540;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // class codes not named in the package
  localparam logic [2:0] CLS_INT    = 3'd0;
  localparam logic [2:0] CLS_LOAD   = 3'd2;
  localparam logic [2:0] CLS_FP_ADD = 3'd4;
  localparam logic [2:0] CLS_ODD_LO = 3'd6;
  localparam logic [2:0] CLS_ODD_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic [2:0]  req_type;
  logic [31:0] instr_addr;
  logic [2:0]  op_class;
  logic [2:0]  skip;
  logic [5:0]  free_active;
  logic [4:0]  free_int;
  logic [4:0]  free_address;
  logic [4:0]  free_fp;
  logic        busy;
  logic        done;
  logic        accepted;
  logic        ready_valid;
  logic [31:0] ready_addr;
  logic [3:0]  free_spots;
  logic [3:0]  occupancy;
  int          errors;
  int          outstanding;
  int          checked;

  int          sent_by_type [8];
  logic [31:0] addr_pool [12];

  decode_dispatch_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .instr_addr   (instr_addr),
    .op_class     (op_class),
    .skip         (skip),
    .free_active  (free_active),
    .free_int     (free_int),
    .free_address (free_address),
    .free_fp      (free_fp),
    .done         (done),
    .accepted     (accepted),
    .ready_valid  (ready_valid),
    .ready_addr   (ready_addr),
    .free_spots   (free_spots),
    .occupancy    (occupancy)
  );

  dispatch_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .instr_addr   (instr_addr),
    .op_class     (op_class),
    .skip         (skip),
    .free_active  (free_active),
    .free_int     (free_int),
    .free_address (free_address),
    .free_fp      (free_fp),
    .done         (done),
    .accepted     (accepted),
    .ready_valid  (ready_valid),
    .ready_addr   (ready_addr),
    .free_spots   (free_spots),
    .occupancy    (occupancy),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // returns just after the edge at which the item was taken
  task automatic send_item(input logic [2:0] req, input logic [31:0] addr,
                           input logic [2:0] cls, input logic [2:0] sk,
                           input logic [5:0] act, input logic [4:0] iq,
                           input logic [4:0] aq, input logic [4:0] fq);
    @(negedge clk);
    start <= 1'b1;
    req_type <= req;
    instr_addr <= addr;
    op_class <= cls;
    skip <= sk;
    free_active <= act;
    free_int <= iq;
    free_address <= aq;
    free_fp <= fq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_type[req]++;
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [2:0] pick_request(input int phase);
    int r;
    int add_w;
    int rem_w;
    add_w = (phase == 0) ? 45 : (phase == 1) ? 30 : 15;
    rem_w = (phase == 0) ? 10 : (phase == 1) ? 20 : 35;
    r = $urandom_range(0, 99);
    if (r < add_w) return REQ_ADD;
    if (r < add_w + rem_w) return REQ_REMOVE;
    r = $urandom_range(0, 49);
    if (r < 18) return REQ_READY;
    if (r < 34) return REQ_SPOTS;
    if (r < 47) return REQ_TICK;
    return 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int          i;
    int          phase;
    logic [2:0]  req;
    logic [31:0] addr;
    logic [2:0]  cls;
    logic [5:0]  act;
    logic [4:0]  iq;
    logic [4:0]  aq;
    logic [4:0]  fq;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ADD;
    instr_addr = '0;
    op_class = CLS_INT;
    skip = '0;
    free_active = '0;
    free_int = '0;
    free_address = '0;
    free_fp = '0;
    foreach (sent_by_type[k]) sent_by_type[k] = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (i = 2; i < 12; i++) addr_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue
    send_item(REQ_READY,  32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_SPOTS,  32'hFFFF_FFFF, CLS_INT,    3'd7, 6'd32, 5'd16, 5'd16, 5'd16);
    send_item(REQ_REMOVE, 32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    // fill to the brim, one of each class plus out of range ones and a duplicate
    send_item(REQ_ADD,    32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_ADD,    32'hFFFF_FFFF, CLS_ODD_HI, 3'd7, 6'h3F, 5'h1F, 5'h1F, 5'h1F);
    send_item(REQ_ADD,    32'h1234_5678, CLS_LOAD,   3'd1, 6'd1,  5'd1,  5'd1,  5'd1);
    send_item(REQ_ADD,    32'hFFFF_FFFF, CLS_FP_ADD, 3'd2, 6'd2,  5'd2,  5'd2,  5'd2);
    send_item(REQ_ADD,    32'h8000_0001, CLS_BRANCH, 3'd3, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_ADD,    32'h5555_AAAA, CLS_STORE,  3'd4, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_ADD,    32'hAAAA_5555, CLS_FP_MUL, 3'd5, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_ADD,    32'h0F0F_0F0F, CLS_ODD_LO, 3'd6, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_ADD,    32'hDEAD_BEEF, CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    // nothing ready yet, then count down to one and tick again at one
    send_item(REQ_READY,  32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_TICK,   32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_TICK,   32'h0,         CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_READY,  32'h0,         CLS_INT,    3'd7, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_READY,  32'h0,         CLS_INT,    3'd3, 6'd0,  5'd0,  5'd0,  5'd0);
    // free-spot walk: no active spot, all room, blocked head, partial walk
    send_item(REQ_SPOTS,  32'h0,         CLS_INT,    3'd0, 6'd0,  5'h1F, 5'h1F, 5'h1F);
    send_item(REQ_SPOTS,  32'h0,         CLS_INT,    3'd0, 6'h3F, 5'h1F, 5'h1F, 5'h1F);
    send_item(REQ_SPOTS,  32'h0,         CLS_INT,    3'd0, 6'd3,  5'd0,  5'd9,  5'd9);
    send_item(REQ_SPOTS,  32'h0,         CLS_INT,    3'd0, 6'd8,  5'd1,  5'd1,  5'd1);
    // duplicate goes from nearest the head, then a miss
    send_item(REQ_REMOVE, 32'hFFFF_FFFF, CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_REMOVE, 32'hDEAD_BEEF, CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    send_item(REQ_SPARE_HI, 32'hFFFF_FFFF, CLS_ODD_HI, 3'd7, 6'h3F, 5'h1F, 5'h1F, 5'h1F);
    send_item(REQ_SPARE_LO, 32'h0,       CLS_INT,    3'd0, 6'd0,  5'd0,  5'd0,  5'd0);
    drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // phases lean towards filling, mixing and draining in turn
      phase = (i / 60) % 3;
      req = pick_request(phase);
      addr = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 11)] : $urandom;
      cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(CLS_ODD_LO, CLS_ODD_HI))
                                        : 3'($urandom_range(CLS_INT, CLS_FP_MUL));
      act = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 9));
      iq = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
      aq = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
      fq = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
      send_item(req, addr, cls, 3'($urandom), act, iq, aq, fq);
      if (i % 150 == 149) drain();
      else if ((i / 90) % 4 != 3) idle_for(pick_gap());
    end
    drain();
    repeat (20) @(negedge clk);

    $display("run covered %0d add, %0d remove, %0d ready, %0d free-spot, %0d tick, %0d unused",
             sent_by_type[REQ_ADD], sent_by_type[REQ_REMOVE], sent_by_type[REQ_READY],
             sent_by_type[REQ_SPOTS], sent_by_type[REQ_TICK],
             sent_by_type[5] + sent_by_type[6] + sent_by_type[7]);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ddb_pkg.sv
rtl/core/ddb_ctrl.sv
rtl/core/ddb_datapath.sv
rtl/core/decode_dispatch_buffer.sv
bench/dispatch_checker.sv
bench/tb_top.sv
